>>> hw/rtl/i2da_pkg.sv
package i2da_pkg;

  localparam int DIGITS        = 10;
  localparam int BCD_W         = 4 * DIGITS;
  localparam int IDX_W         = 4;
  localparam int CNT_W         = 4;
  localparam int DABBLE_STAGES = 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic valid;
    logic neg;
  } i2da_ctl_t;

endpackage

>>> hw/rtl/i2da_dabble.sv
module i2da_dabble import i2da_pkg::*; #(
  parameter int MAG_W = 32,
  parameter int STEPS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  i2da_ctl_t        in_ctl,
  input  logic [MAG_W-1:0] in_mag,
  input  logic [BCD_W-1:0] in_bcd,
  output i2da_ctl_t        out_ctl,
  output logic [MAG_W-1:0] out_mag,
  output logic [BCD_W-1:0] out_bcd
);

  i2da_ctl_t        ctl_r;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;

  // shift-add-3, STEPS bits per stage
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [MAG_W-1:0] m;
    b = in_bcd;
    m = in_mag;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      {b, m} = {b[BCD_W-2:0], m, 1'b0};
    end
    bcd_nxt = b;
    mag_nxt = m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (load) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag_r <= mag_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign out_ctl = ctl_r;
  assign out_mag = mag_r;
  assign out_bcd = bcd_r;

endmodule

>>> hw/rtl/i2da_serial.sv
module i2da_serial import i2da_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  i2da_ctl_t        in_ctl,
  input  logic [BCD_W-1:0] in_bcd,
  output logic             ready,
  output logic             out_valid,
  output logic [7:0]       out_char_code,
  output logic             out_last,
  output logic [CNT_W-1:0] out_count
);

  logic             active_r;
  logic             neg_pend_r;
  logic [IDX_W-1:0] idx_r;
  logic [BCD_W-1:0] bcd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             valid_r;
  logic [7:0]       char_r, char_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] ocnt_r;
  logic [IDX_W-1:0] nd;
  logic             load;

  // significant digit count, at least one
  always_comb begin
    nd = IDX_W'(1);
    for (int d = 1; d < DIGITS; d++) begin
      if (in_bcd[d*4 +: 4] != 4'd0) begin
        nd = IDX_W'(d + 1);
      end
    end
  end

  assign ready = !active_r || (!neg_pend_r && idx_r == '0);
  assign load  = ready && in_ctl.valid;

  always_comb begin
    if (neg_pend_r) begin
      char_nxt = CH_MINUS;
      last_nxt = 1'b0;
    end else begin
      char_nxt = CH_ZERO + {4'd0, bcd_r[idx_r*4 +: 4]};
      last_nxt = (idx_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      neg_pend_r <= 1'b0;
      idx_r      <= '0;
      valid_r    <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      valid_r <= active_r;
      last_r  <= active_r && last_nxt;
      if (load) begin
        active_r   <= 1'b1;
        neg_pend_r <= in_ctl.neg;
        idx_r      <= nd - IDX_W'(1);
      end else if (active_r) begin
        if (neg_pend_r) begin
          neg_pend_r <= 1'b0;
        end else if (idx_r == '0) begin
          active_r <= 1'b0;
        end else begin
          idx_r <= idx_r - IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd_r <= in_bcd;
      cnt_r <= CNT_W'(nd) + CNT_W'(in_ctl.neg);
    end
    char_r <= char_nxt;
    ocnt_r <= last_nxt ? cnt_r : '0;
  end

  assign out_valid     = valid_r;
  assign out_char_code = char_r;
  assign out_last      = last_r;
  assign out_count     = last_r ? ocnt_r : '0;

endmodule

>>> hw/rtl/int_to_decimal_ascii.sv
// channel | ports                                      | handshake
// input   | in_value, in_mode                          | start, busy
// result  | out_char_code, out_last, out_count         | out_valid strobe
//
// One result per cycle, one per character: an item is 1 to 11 characters
// (sign plus significant digits), set by the character serializer.
// From accept to first character an item passes the sign stage, four
// shift-add-3 stages, the serializer load and the output register.
// rst_n is synchronous and clears all valid bits and the serializer.
// busy stalls the input while the pipeline is backed up behind the
// serializer; the receiver cannot stall.
module int_to_decimal_ascii import i2da_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [31:0]      in_value,
  input  logic             in_mode,
  output logic             out_valid,
  output logic [7:0]       out_char_code,
  output logic             out_last,
  output logic [CNT_W-1:0] out_count
);

  localparam int STEPS = (VALUE_WIDTH + DABBLE_STAGES - 1) / DABBLE_STAGES;
  localparam int MAG_W = STEPS * DABBLE_STAGES;

  logic [VALUE_WIDTH-1:0] word;
  logic                   neg;
  i2da_ctl_t              ctl0_r;
  logic [MAG_W-1:0]       mag0_r, mag0_nxt;

  i2da_ctl_t              ctl   [DABBLE_STAGES+1];
  logic [MAG_W-1:0]       mag   [DABBLE_STAGES+1];
  logic [BCD_W-1:0]       bcd   [DABBLE_STAGES+1];
  logic                   rdy   [DABBLE_STAGES+2];
  logic                   ser_ready;
  logic                   accept;

  assign word     = in_value[VALUE_WIDTH-1:0];
  assign neg      = in_mode && word[VALUE_WIDTH-1];
  assign mag0_nxt = MAG_W'(neg ? (~word + VALUE_WIDTH'(1)) : word);

  assign rdy[DABBLE_STAGES+1] = ser_ready;
  assign rdy[0] = !ctl0_r.valid || rdy[1];
  assign busy   = !rdy[0];
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (rdy[0]) begin
      ctl0_r.valid <= accept;
      ctl0_r.neg   <= neg;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag0_r <= mag0_nxt;
    end
  end

  assign ctl[0] = ctl0_r;
  assign mag[0] = mag0_r;
  assign bcd[0] = '0;

  for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dab
    assign rdy[g+1] = !ctl[g+1].valid || rdy[g+2];
    i2da_dabble #(
      .MAG_W (MAG_W),
      .STEPS (STEPS)
    ) u_dab (
      .clk     (clk),
      .rst_n   (rst_n),
      .load    (rdy[g+1]),
      .in_ctl  (ctl[g]),
      .in_mag  (mag[g]),
      .in_bcd  (bcd[g]),
      .out_ctl (ctl[g+1]),
      .out_mag (mag[g+1]),
      .out_bcd (bcd[g+1])
    );
  end

  i2da_serial u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ctl        (ctl[DABBLE_STAGES]),
    .in_bcd        (bcd[DABBLE_STAGES]),
    .ready         (ser_ready),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .out_count     (out_count)
  );

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ctl0_r.valid)
    else $error("accepted item not captured");

  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last without strobe");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_count != '0 && out_count <= CNT_W'(11))
    else $error("bad character count");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == CH_MINUS) ||
                  (out_char_code >= CH_ZERO && out_char_code <= CH_ZERO + 8'd9))
    else $error("bad character");

  a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code == CH_MINUS |-> !out_last)
    else $error("minus sign ends an item");

endmodule

>>> verif/int_to_decimal_ascii_test.sv
module int_to_decimal_ascii_test import i2da_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 24;
  localparam int RANDOM_ITEMS = 150;

  typedef struct {
    logic [31:0] value;
    logic        mode;
    int          gap_pct;
    bit          drain;
  } number_t;

  typedef struct {
    logic [7:0]       ch;
    logic             last;
    logic [CNT_W-1:0] cnt;
  } ascii_char_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [31:0]      in_value = '0;
  logic             in_mode = 1'b0;
  logic             out_valid;
  logic [7:0]       out_char_code;
  logic             out_last;
  logic [CNT_W-1:0] out_count;

  number_t     numbers_to_send[$];
  ascii_char_t chars_due[$];
  logic        took_number = 1'b0;
  int          errors = 0;
  int          cycles = 0;

  int_to_decimal_ascii #(.VALUE_WIDTH(VW)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .in_mode(in_mode),
    .out_valid(out_valid),
    .out_char_code(out_char_code),
    .out_last(out_last),
    .out_count(out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chars outstanding", cycles, chars_due.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (errors < 40) $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // decimal text of one number, most significant char first
  function automatic void predict_text(input logic [31:0] v, input logic m);
    logic [VW-1:0] w;
    logic [VW-1:0] mag;
    logic [7:0]    digs[$];
    logic          neg;
    int            n;
    ascii_char_t   c;
    w = v[VW-1:0];
    neg = m && w[VW-1];
    mag = neg ? (~w + 1'b1) : w;
    do begin
      digs.push_front(8'(CH_ZERO + 8'(mag % 10)));
      mag = mag / 10;
    end while (mag != 0 && digs.size() < DIGITS);
    n = digs.size() + (neg ? 1 : 0);
    if (neg) begin
      c.ch = CH_MINUS;
      c.last = 1'b0;
      c.cnt = '0;
      chars_due.push_back(c);
    end
    foreach (digs[i]) begin
      c.ch = digs[i];
      c.last = (i == digs.size() - 1);
      c.cnt = c.last ? CNT_W'(n) : '0;
      chars_due.push_back(c);
    end
  endfunction

  // driver
  always @(negedge clk) begin
    logic nxt_start;
    nxt_start = start;
    if (rst_n && (!start || took_number)) begin
      nxt_start = 1'b0;
      if (numbers_to_send.size() != 0 &&
          !(numbers_to_send[0].drain && chars_due.size() != 0) &&
          $urandom_range(99) >= numbers_to_send[0].gap_pct) begin
        in_value <= numbers_to_send[0].value;
        in_mode <= numbers_to_send[0].mode;
        void'(numbers_to_send.pop_front());
        nxt_start = 1'b1;
      end
    end
    start <= nxt_start;
  end

  // monitor and checker
  always @(posedge clk) begin
    ascii_char_t want;
    took_number <= rst_n && start && !busy;
    if (rst_n && start && !busy) predict_text(in_value, in_mode);
    if (rst_n && out_valid) begin
      if (chars_due.size() == 0) begin
        report_mismatch($sformatf("char 0x%02h with nothing expected", out_char_code));
      end else begin
        want = chars_due.pop_front();
        if (out_char_code !== want.ch)
          report_mismatch($sformatf("char 0x%02h, want 0x%02h", out_char_code, want.ch));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_last, want.last));
        if (out_count !== want.cnt)
          report_mismatch($sformatf("count %0d, want %0d", out_count, want.cnt));
      end
    end
  end

  task automatic add_number(input logic [31:0] v, input logic m, input int pct, input bit drain);
    number_t it;
    it.value = v;
    it.mode = m;
    it.gap_pct = pct;
    it.drain = drain;
    numbers_to_send.push_back(it);
  endtask

  function automatic logic [31:0] pick_value();
    int     k;
    longint p;
    k = $urandom_range(9);
    p = 1;
    repeat (k) p = p * 10;
    case ($urandom_range(3))
      0: return $urandom;
      1: return (k == 9) ? 32'($urandom) : 32'($urandom % (p * 10));
      2: return 32'(p) + 32'($urandom_range(2)) - 32'd1;
      default: return 32'($urandom_range(9));
    endcase
  endfunction

  initial begin
    int          pct;
    logic [31:0] v;
    logic        m;

    // directed
    add_number(32'd0, 1'b0, 33, 1'b0);
    add_number(32'd0, 1'b1, 33, 1'b0);
    add_number(32'hFFFF_FFFF, 1'b0, 33, 1'b0);
    add_number(32'hFFFF_FFFF, 1'b1, 33, 1'b0);
    add_number(32'h8000_0000, 1'b1, 33, 1'b0);
    add_number(32'h8000_0000, 1'b0, 33, 1'b0);
    add_number(32'h7FFF_FFFF, 1'b1, 33, 1'b0);
    add_number(32'h7FFF_FFFF, 1'b0, 33, 1'b0);
    add_number(32'h8000_0001, 1'b1, 33, 1'b0);
    add_number(32'd1, 1'b1, 33, 1'b0);
    add_number(32'd9, 1'b0, 33, 1'b0);
    add_number(32'd10, 1'b0, 33, 1'b0);
    add_number(-32'sd10, 1'b1, 33, 1'b0);
    add_number(32'd99, 1'b1, 33, 1'b0);
    add_number(32'd100, 1'b0, 33, 1'b0);
    add_number(32'd999_999_999, 1'b0, 33, 1'b0);
    add_number(32'd1_000_000_000, 1'b1, 33, 1'b0);
    add_number(-32'sd1_000_000_000, 1'b1, 33, 1'b0);
    add_number(32'd4_000_000_000, 1'b0, 33, 1'b0);
    add_number(32'hAAAA_AAAA, 1'b0, 33, 1'b0);
    add_number(32'h5555_5555, 1'b1, 33, 1'b0);

    // random, three idle phases
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pct = (i < RANDOM_ITEMS / 3) ? 33 : (i < 2 * RANDOM_ITEMS / 3) ? 76 : 0;
      m = $urandom_range(1);
      v = pick_value();
      if (m && $urandom_range(1)) v = -v;
      add_number(v, m, pct,
                 i == 0 || i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3 ||
                 $urandom_range(99) < 4);
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (numbers_to_send.size() != 0 || start) @(posedge clk);
    while (chars_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/i2da_pkg.sv
hw/rtl/i2da_dabble.sv
hw/rtl/i2da_serial.sv
hw/rtl/int_to_decimal_ascii.sv
verif/int_to_decimal_ascii_test.sv
